// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands. Each expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/ibam_pkg.sv =====
// ----------------------------------------------------------------------------
// ibam_pkg
// Types, constants and helpers for the image border address map.
// ----------------------------------------------------------------------------
package ibam_pkg;

  localparam int MAX_DIM         = 4096;
  localparam int MAX_BORDER      = 1024;
  localparam int DIM_W           = 13;
  localparam int COORD_W         = 12;
  localparam int BORDER_W        = 11;
  localparam int CALC_W          = 14;
  localparam int DIST_W          = 10;
  localparam int REM_W           = 14;
  localparam int STEPS_PER_STAGE = 2;
  localparam int MOD_STAGES      = DIST_W / STEPS_PER_STAGE;
  localparam int CFG_ADDR_W      = 3;
  localparam int CFG_DATA_W      = 32;

  localparam logic [31:0] BLACK_OPAQUE = 32'hFF00_0000;

  localparam logic [CFG_ADDR_W-1:0] REG_BORDER_MODE  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_FILL_COLOR   = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_WIDTH  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_HEIGHT = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_BORDER_WIDTH = 3'd4;

  typedef enum logic [2:0] {
    MODE_ZERO    = 3'd0,
    MODE_CONST   = 3'd1,
    MODE_COPY    = 3'd2,
    MODE_REFLECT = 3'd3,
    MODE_WRAP    = 3'd4
  } mode_t;

  typedef struct packed {
    logic [12:0] out_x;
    logic [12:0] out_y;
  } in_t;

  typedef struct packed {
    logic        take_source;
    logic [11:0] source_x;
    logic [11:0] source_y;
    logic [31:0] fill_pixel;
  } out_t;

  typedef struct packed {
    logic [2:0]          border_mode;
    logic [31:0]         fill_color;
    logic [DIM_W-1:0]    image_width;
    logic [DIM_W-1:0]    image_height;
    logic [BORDER_W-1:0] border_width;
  } cfg_t;

  typedef struct packed {
    logic               take_source;
    logic [31:0]        fill_pixel;
    logic [COORD_W-1:0] source_x;
    logic [COORD_W-1:0] source_y;
    logic               band;
    logic               axis_y;
    logic               far_side;
    mode_t              mode;
    logic [DIM_W-1:0]   n;
    logic [REM_W-1:0]   m;
    logic [DIST_W-1:0]  band_dist;
    logic [REM_W-1:0]   rem;
  } mid_t;

  localparam cfg_t CFG_RESET = '{
    border_mode:  MODE_CONST,
    fill_color:   BLACK_OPAQUE,
    image_width:  13'd1,
    image_height: 13'd1,
    border_width: 11'd0
  };

  // One restoring long-division step: bring in one dividend bit.
  function automatic logic [REM_W-1:0] mod_step(input logic [REM_W-1:0] r,
                                                input logic [REM_W-1:0] m,
                                                input logic             b);
    logic [REM_W:0] s;
    s = {r, b};
    if (s >= {1'b0, m}) begin
      s = s - {1'b0, m};
    end
    return s[REM_W-1:0];
  endfunction

endpackage

// ===== sv/ibam_classify.sv =====
// ----------------------------------------------------------------------------
// ibam_classify
// First stage: region decode, fill selection, band distance and divisor.
// ----------------------------------------------------------------------------
module ibam_classify (
  input  logic           clk,
  input  logic           rst_n,
  input  ibam_pkg::cfg_t cfg,
  input  logic           in_valid,
  output logic           in_ready,
  input  ibam_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output ibam_pkg::mid_t out_data
);

  logic                             v_r;
  ibam_pkg::mid_t                   data_r;
  ibam_pkg::mid_t                   data_nxt;
  logic [ibam_pkg::DIM_W-1:0]       w;
  logic [ibam_pkg::DIM_W-1:0]       h;
  logic [ibam_pkg::BORDER_W-1:0]    t;
  ibam_pkg::mode_t                  mode;
  logic [ibam_pkg::CALC_W-1:0]      x14, y14, w14, h14, t14;
  logic [ibam_pkg::CALC_W-1:0]      ow, oh, tw, th;
  logic [ibam_pkg::CALC_W-1:0]      ix, iy, near_dx, near_dy, far_dx, far_dy;
  logic                             in_frame, in_x, in_y;

  always_comb begin
    if (cfg.image_width == '0) begin
      w = ibam_pkg::DIM_W'(1);
    end else if (cfg.image_width > ibam_pkg::DIM_W'(ibam_pkg::MAX_DIM)) begin
      w = ibam_pkg::DIM_W'(ibam_pkg::MAX_DIM);
    end else begin
      w = cfg.image_width;
    end
    if (cfg.image_height == '0) begin
      h = ibam_pkg::DIM_W'(1);
    end else if (cfg.image_height > ibam_pkg::DIM_W'(ibam_pkg::MAX_DIM)) begin
      h = ibam_pkg::DIM_W'(ibam_pkg::MAX_DIM);
    end else begin
      h = cfg.image_height;
    end
    if (cfg.border_width > ibam_pkg::BORDER_W'(ibam_pkg::MAX_BORDER)) begin
      t = ibam_pkg::BORDER_W'(ibam_pkg::MAX_BORDER);
    end else begin
      t = cfg.border_width;
    end
    if (cfg.border_mode > ibam_pkg::MODE_WRAP) begin
      mode = ibam_pkg::MODE_ZERO;
    end else begin
      mode = ibam_pkg::mode_t'(cfg.border_mode);
    end
  end

  always_comb begin
    x14      = ibam_pkg::CALC_W'(in_data.out_x);
    y14      = ibam_pkg::CALC_W'(in_data.out_y);
    w14      = ibam_pkg::CALC_W'(w);
    h14      = ibam_pkg::CALC_W'(h);
    t14      = ibam_pkg::CALC_W'(t);
    ow       = w14 + {t14[ibam_pkg::CALC_W-2:0], 1'b0};
    oh       = h14 + {t14[ibam_pkg::CALC_W-2:0], 1'b0};
    tw       = t14 + w14;
    th       = t14 + h14;
    in_frame = (x14 < ow) && (y14 < oh);
    in_x     = (x14 >= t14) && (x14 < tw);
    in_y     = (y14 >= t14) && (y14 < th);
    ix       = x14 - t14;
    iy       = y14 - t14;
    near_dx  = t14 - x14 - ibam_pkg::CALC_W'(1);
    near_dy  = t14 - y14 - ibam_pkg::CALC_W'(1);
    far_dx   = x14 - tw;
    far_dy   = y14 - th;
  end

  always_comb begin
    data_nxt             = '0;
    data_nxt.mode        = mode;
    data_nxt.m           = ibam_pkg::REM_W'(1);
    data_nxt.n           = ibam_pkg::DIM_W'(1);
    if (in_frame) begin
      if (in_x && in_y) begin
        data_nxt.take_source = 1'b1;
        data_nxt.source_x    = ix[ibam_pkg::COORD_W-1:0];
        data_nxt.source_y    = iy[ibam_pkg::COORD_W-1:0];
      end else if (mode == ibam_pkg::MODE_ZERO) begin
        data_nxt.fill_pixel = ibam_pkg::BLACK_OPAQUE;
      end else if (mode == ibam_pkg::MODE_CONST) begin
        data_nxt.fill_pixel = cfg.fill_color;
      end else if (in_x) begin
        data_nxt.take_source = 1'b1;
        data_nxt.band        = 1'b1;
        data_nxt.axis_y      = 1'b1;
        data_nxt.source_x    = ix[ibam_pkg::COORD_W-1:0];
        data_nxt.far_side    = (y14 >= t14);
        data_nxt.band_dist   = (y14 >= t14) ? far_dy[ibam_pkg::DIST_W-1:0]
                                            : near_dy[ibam_pkg::DIST_W-1:0];
        data_nxt.n           = h;
      end else if (in_y) begin
        data_nxt.take_source = 1'b1;
        data_nxt.band        = 1'b1;
        data_nxt.source_y    = iy[ibam_pkg::COORD_W-1:0];
        data_nxt.far_side    = (x14 >= t14);
        data_nxt.band_dist   = (x14 >= t14) ? far_dx[ibam_pkg::DIST_W-1:0]
                                            : near_dx[ibam_pkg::DIST_W-1:0];
        data_nxt.n           = w;
      end
    end
    if (mode == ibam_pkg::MODE_REFLECT) begin
      data_nxt.m = {data_nxt.n, 1'b0};
    end else begin
      data_nxt.m = ibam_pkg::REM_W'(data_nxt.n);
    end
  end

  assign in_ready = !v_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_data  = data_r;

endmodule

// ===== sv/ibam_mod_stage.sv =====
// ----------------------------------------------------------------------------
// ibam_mod_stage
// One slice of the band-distance remainder: two long-division steps.
// ----------------------------------------------------------------------------
module ibam_mod_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  ibam_pkg::mid_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output ibam_pkg::mid_t out_data
);

  logic           v_r;
  ibam_pkg::mid_t data_r;
  ibam_pkg::mid_t data_nxt;

  always_comb begin
    data_nxt = in_data;
    for (int i = 0; i < ibam_pkg::STEPS_PER_STAGE; i++) begin
      data_nxt.rem       = ibam_pkg::mod_step(data_nxt.rem, data_nxt.m,
                                              data_nxt.band_dist[ibam_pkg::DIST_W-1]);
      data_nxt.band_dist = {data_nxt.band_dist[ibam_pkg::DIST_W-2:0], 1'b0};
    end
  end

  assign in_ready = !v_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_data  = data_r;

endmodule

// ===== sv/ibam_resolve.sv =====
// ----------------------------------------------------------------------------
// ibam_resolve
// Last stage: folds the remainder into a band index and registers the result.
// ----------------------------------------------------------------------------
module ibam_resolve (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  ibam_pkg::mid_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output ibam_pkg::out_t out_data
);

  logic                        v_r;
  ibam_pkg::out_t              data_r;
  ibam_pkg::out_t              data_nxt;
  logic [ibam_pkg::REM_W-1:0]  n14, nm1, rem, inv, over, mirror, idx;
  logic                        lt;

  always_comb begin
    n14    = ibam_pkg::REM_W'(in_data.n);
    rem    = in_data.rem;
    lt     = rem < n14;
    nm1    = n14 - ibam_pkg::REM_W'(1);
    inv    = nm1 - rem;
    over   = rem - n14;
    mirror = in_data.m - rem - ibam_pkg::REM_W'(1);
    case (in_data.mode)
      ibam_pkg::MODE_COPY: begin
        idx = in_data.far_side ? nm1 : '0;
      end
      ibam_pkg::MODE_WRAP: begin
        idx = in_data.far_side ? rem : inv;
      end
      ibam_pkg::MODE_REFLECT: begin
        if (in_data.far_side) begin
          idx = lt ? inv : over;
        end else begin
          idx = lt ? rem : mirror;
        end
      end
      default: begin
        idx = '0;
      end
    endcase
  end

  always_comb begin
    data_nxt.take_source = in_data.take_source;
    data_nxt.fill_pixel  = in_data.fill_pixel;
    data_nxt.source_x    = in_data.source_x;
    data_nxt.source_y    = in_data.source_y;
    if (in_data.band) begin
      if (in_data.axis_y) begin
        data_nxt.source_y = idx[ibam_pkg::COORD_W-1:0];
      end else begin
        data_nxt.source_x = idx[ibam_pkg::COORD_W-1:0];
      end
    end
  end

  assign in_ready = !v_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_data  = data_r;

endmodule

// ===== sv/image_border_address_map_unit.sv =====
// ----------------------------------------------------------------------------
// image_border_address_map_unit
// Maps a bordered-image pixel coordinate to a source fetch or a fill pixel.
//
//   port group  dir  handshake          payload
//   in_*        in   in_valid/in_ready  ibam_pkg::in_t  (out_x, out_y)
//   out_*       out  out_valid/out_ready ibam_pkg::out_t (take_source, ...)
//   cfg_*       in   cfg_we             cfg_addr, cfg_wdata
//
// One beat per cycle sustained while out_ready holds; the stages are the decode
// stage, five remainder stages of two division steps each, and the output stage.
// The remainder chain (one step per dividend bit) sets the depth.
// Synchronous active-low reset clears valids and loads config registers with CFG_RESET.
// A stall holds each full stage; empty stages keep filling behind it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module image_border_address_map_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  ibam_pkg::in_t                     in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output ibam_pkg::out_t                    out_data,
  input  logic                              cfg_we,
  input  logic [ibam_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [ibam_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  ibam_pkg::cfg_t cfg_r;
  ibam_pkg::cfg_t cfg_nxt;
  ibam_pkg::mid_t mid      [ibam_pkg::MOD_STAGES+1];
  logic           mid_vld  [ibam_pkg::MOD_STAGES+1];
  logic           mid_rdy  [ibam_pkg::MOD_STAGES+1];

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_addr)
        ibam_pkg::REG_BORDER_MODE:  cfg_nxt.border_mode  = cfg_wdata[2:0];
        ibam_pkg::REG_FILL_COLOR:   cfg_nxt.fill_color   = cfg_wdata[31:0];
        ibam_pkg::REG_IMAGE_WIDTH:  cfg_nxt.image_width  = cfg_wdata[ibam_pkg::DIM_W-1:0];
        ibam_pkg::REG_IMAGE_HEIGHT: cfg_nxt.image_height = cfg_wdata[ibam_pkg::DIM_W-1:0];
        ibam_pkg::REG_BORDER_WIDTH: cfg_nxt.border_width = cfg_wdata[ibam_pkg::BORDER_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= ibam_pkg::CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  ibam_classify u_classify (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (mid_vld[0]),
    .out_ready (mid_rdy[0]),
    .out_data  (mid[0])
  );

  for (genvar s = 0; s < ibam_pkg::MOD_STAGES; s++) begin : g_mod
    ibam_mod_stage u_mod (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (mid_vld[s]),
      .in_ready  (mid_rdy[s]),
      .in_data   (mid[s]),
      .out_valid (mid_vld[s+1]),
      .out_ready (mid_rdy[s+1]),
      .out_data  (mid[s+1])
    );
  end

  ibam_resolve u_resolve (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (mid_vld[ibam_pkg::MOD_STAGES]),
    .in_ready  (mid_rdy[ibam_pkg::MOD_STAGES]),
    .in_data   (mid[ibam_pkg::MOD_STAGES]),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  `ASSERT_IMP(a_fetch_no_fill, out_valid && out_data.take_source,
              out_data.fill_pixel == '0, "fetch beat carries a fill value")
  `ASSERT_IMP(a_fill_no_coord, out_valid && !out_data.take_source,
              out_data.source_x == '0 && out_data.source_y == '0,
              "fill beat carries a source coordinate")
  `ASSERT_IMP(a_empty_out_ready, !out_valid, in_ready,
              "input stalled with empty output stage")

endmodule
